>>> sv/sdio_transfer_splitter_assert.svh
`ifndef SDIO_TRANSFER_SPLITTER_ASSERT_SVH
`define SDIO_TRANSFER_SPLITTER_ASSERT_SVH

// Check that a property holds on every clock edge outside reset.
`define SDIO_TS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sdio_ts assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define SDIO_TS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdio_ts implication failed");

`endif

>>> sv/sdio_ts_pkg.sv
package sdio_ts_pkg;

  localparam int unsigned BYTES_W = 13;
  localparam int unsigned ADDR_W  = 17;
  localparam int unsigned BS_W    = 12;
  localparam int unsigned MAXB_W  = 9;
  localparam int unsigned CHUNK_W = 10;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned DIV_W   = BYTES_W;
  localparam int unsigned STEP_W  = 4;

  localparam logic [BYTES_W-1:0] MAX_TRANSFER_BYTES = 13'd4096;
  localparam logic [CNT_W-1:0]   RESULT_CAP         = 7'd64;
  localparam logic [BS_W-1:0]    BS_MIN             = 12'd128;
  localparam logic [CHUNK_W-1:0] CHUNK_MIN          = 10'd64;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX          = 10'd512;
  localparam logic [STEP_W-1:0]  DIV_LAST_STEP      = 4'(DIV_W - 1);

  localparam logic [1:0] REG_MBE   = 2'd0;
  localparam logic [1:0] REG_BS    = 2'd1;
  localparam logic [1:0] REG_MAXB  = 2'd2;
  localparam logic [1:0] REG_CHUNK = 2'd3;

  typedef struct packed {
    logic               mbe;
    logic [BS_W-1:0]    bs;
    logic [MAXB_W-1:0]  maxb;
    logic [CHUNK_W-1:0] chunk;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [BS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BCHK  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_BEMIT = 6'b010000,
    ST_BYTE  = 6'b100000
  } state_e;

endpackage

>>> sv/sdio_ts_cfg.sv
module sdio_ts_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sdio_ts_pkg::cfg_t  cfg_o
);

  logic                             mbe_q, mbe_d;
  logic [sdio_ts_pkg::BS_W-1:0]     bs_q, bs_d;
  logic [sdio_ts_pkg::MAXB_W-1:0]   maxb_q, maxb_d;
  logic [sdio_ts_pkg::CHUNK_W-1:0]  chunk_q, chunk_d;
  logic                             wr_en;
  logic [1:0]                       idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_comb begin
    mbe_d   = mbe_q;
    bs_d    = bs_q;
    maxb_d  = maxb_q;
    chunk_d = chunk_q;
    if (wr_en) begin
      case (idx)
        sdio_ts_pkg::REG_MBE:   mbe_d   = pwdata[0];
        sdio_ts_pkg::REG_BS:    bs_d    = pwdata[sdio_ts_pkg::BS_W-1:0];
        sdio_ts_pkg::REG_MAXB:  maxb_d  = pwdata[sdio_ts_pkg::MAXB_W-1:0];
        sdio_ts_pkg::REG_CHUNK: chunk_d = pwdata[sdio_ts_pkg::CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbe_q   <= 1'b1;
      bs_q    <= 12'd512;
      maxb_q  <= 9'd511;
      chunk_q <= 10'd512;
    end else begin
      mbe_q   <= mbe_d;
      bs_q    <= bs_d;
      maxb_q  <= maxb_d;
      chunk_q <= chunk_d;
    end
  end

  always_comb begin
    case (idx)
      sdio_ts_pkg::REG_MBE:   prdata = {31'd0, mbe_q};
      sdio_ts_pkg::REG_BS:    prdata = {20'd0, bs_q};
      sdio_ts_pkg::REG_MAXB:  prdata = {23'd0, maxb_q};
      sdio_ts_pkg::REG_CHUNK: prdata = {22'd0, chunk_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Clamp into the usable ranges
  always_comb begin
    cfg_o.mbe   = mbe_q;
    cfg_o.bs    = (bs_q < sdio_ts_pkg::BS_MIN) ? sdio_ts_pkg::BS_MIN : bs_q;
    cfg_o.maxb  = (maxb_q == '0) ? 9'd1 : maxb_q;
    if (chunk_q < sdio_ts_pkg::CHUNK_MIN) begin
      cfg_o.chunk = sdio_ts_pkg::CHUNK_MIN;
    end else if (chunk_q > sdio_ts_pkg::CHUNK_MAX) begin
      cfg_o.chunk = sdio_ts_pkg::CHUNK_MAX;
    end else begin
      cfg_o.chunk = chunk_q;
    end
  end

endmodule

>>> sv/sdio_ts_div.sv
module sdio_ts_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sdio_ts_pkg::div_req_t   req_i,
  output sdio_ts_pkg::div_rsp_t   rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [sdio_ts_pkg::STEP_W-1:0]     step_q, step_d;
  logic [sdio_ts_pkg::DIV_W-1:0]      acc_q, acc_d;
  logic [sdio_ts_pkg::DIV_W-1:0]      qd_q, qd_d;
  logic [sdio_ts_pkg::BS_W-1:0]       dvs_q, dvs_d;
  logic [sdio_ts_pkg::DIV_W-1:0]      trial;
  logic                               fits;

  assign trial = {acc_q[sdio_ts_pkg::DIV_W-2:0], qd_q[sdio_ts_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    qd_d   = qd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = '0;
      qd_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      acc_d  = fits ? (trial - {1'b0, dvs_q}) : trial;
      qd_d   = {qd_q[sdio_ts_pkg::DIV_W-2:0], fits};
      step_d = step_q + 4'd1;
      if (step_q == sdio_ts_pkg::DIV_LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    qd_q  <= qd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = qd_q;

endmodule

>>> sv/sdio_transfer_splitter.sv
// Channel   Direction  Payload
// s_axis    in         request: transfer_bytes, increment_address, start_address, ...
// m_axis    out        CMD53 argument and byte count, status in tuser, last in tlast
// APB       in         four registers at byte addresses 0, 4, 8, 12
//
// A request is taken while idle; s_axis_tready is high only between requests.
// Each block-mode command runs a check, the 13-step divider, a multiply and an emit.
// Byte-mode commands need no divide; a request of zero bytes yields nothing.
// Every emission waits while the output register holds a result not yet taken.
// Reset clears the sequencer and sets the registers to their reset values.

`include "sdio_transfer_splitter_assert.svh"

module sdio_transfer_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // write_dir[0], function_number[3:1], start_address[20:4],
  // increment_address[21], transfer_bytes[34:22], zero[39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command_arg[31:0], command_bytes[44:32], zero[47:45]
  output logic [47:0] m_axis_tdata,
  // status[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sdio_ts_pkg::cfg_t     cfg;
  sdio_ts_pkg::div_req_t div_req;
  sdio_ts_pkg::div_rsp_t div_rsp;
  sdio_ts_pkg::state_e   state_q, state_d;

  logic                               wr_q, wr_d;
  logic [2:0]                         fn_q, fn_d;
  logic                               inc_q, inc_d;
  logic [sdio_ts_pkg::ADDR_W:0]       addr_q, addr_d;
  logic [sdio_ts_pkg::BYTES_W-1:0]    rem_q, rem_d;
  logic [sdio_ts_pkg::BS_W-1:0]       bs_q, bs_d;
  logic [sdio_ts_pkg::MAXB_W-1:0]     maxb_q, maxb_d;
  logic [sdio_ts_pkg::CHUNK_W-1:0]    chunk_q, chunk_d;
  logic [sdio_ts_pkg::MAXB_W-1:0]     blocks_q, blocks_d;
  logic [sdio_ts_pkg::BYTES_W-1:0]    sz_q, sz_d;
  logic [sdio_ts_pkg::CNT_W-1:0]      n_q, n_d;

  logic                               ovalid_q, ovalid_d;
  logic [31:0]                        oarg_q, oarg_d;
  logic [sdio_ts_pkg::BYTES_W-1:0]    obytes_q, obytes_d;
  logic                               ostat_q, ostat_d;
  logic                               olast_q, olast_d;

  logic                               in_acc;
  logic                               slot_free;
  logic [sdio_ts_pkg::BYTES_W-1:0]    in_bytes;
  logic [sdio_ts_pkg::BYTES_W-1:0]    in_sat;
  logic [20:0]                        prod;
  logic [sdio_ts_pkg::CHUNK_W-1:0]    bsz;
  logic [sdio_ts_pkg::BYTES_W-1:0]    esz;
  logic [sdio_ts_pkg::BYTES_W-1:0]    rem_new;
  logic [sdio_ts_pkg::CNT_W-1:0]      n_new;
  logic                               run_end;

  sdio_ts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdio_ts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == sdio_ts_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~ovalid_q | m_axis_tready;
  assign in_bytes      = s_axis_tdata[34:22];
  assign in_sat        = (in_bytes > sdio_ts_pkg::MAX_TRANSFER_BYTES) ?
                         sdio_ts_pkg::MAX_TRANSFER_BYTES : in_bytes;

  assign prod    = {12'd0, blocks_q} * {9'd0, bs_q};
  assign bsz     = (rem_q < {3'd0, chunk_q}) ? rem_q[sdio_ts_pkg::CHUNK_W-1:0] : chunk_q;
  assign esz     = (state_q == sdio_ts_pkg::ST_BEMIT) ? sz_q : {3'd0, bsz};
  assign rem_new = rem_q - esz;
  assign n_new   = n_q + 7'd1;
  assign run_end = (rem_new == '0) | (n_new == sdio_ts_pkg::RESULT_CAP);

  assign div_req.start    = (state_q == sdio_ts_pkg::ST_BCHK) & (rem_q >= {1'b0, bs_q});
  assign div_req.dividend = rem_q;
  assign div_req.divisor  = bs_q;

  always_comb begin
    state_d  = state_q;
    wr_d     = wr_q;
    fn_d     = fn_q;
    inc_d    = inc_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    bs_d     = bs_q;
    maxb_d   = maxb_q;
    chunk_d  = chunk_q;
    blocks_d = blocks_q;
    sz_d     = sz_q;
    n_d      = n_q;
    ovalid_d = ovalid_q & ~m_axis_tready;
    oarg_d   = oarg_q;
    obytes_d = obytes_q;
    ostat_d  = ostat_q;
    olast_d  = olast_q;

    case (state_q)
      sdio_ts_pkg::ST_IDLE: begin
        if (in_acc) begin
          wr_d    = s_axis_tdata[0];
          fn_d    = s_axis_tdata[3:1];
          addr_d  = {1'b0, s_axis_tdata[20:4]};
          inc_d   = s_axis_tdata[21];
          rem_d   = in_sat;
          bs_d    = cfg.bs;
          maxb_d  = cfg.maxb;
          chunk_d = cfg.chunk;
          n_d     = '0;
          if (in_sat == '0) begin
            state_d = sdio_ts_pkg::ST_IDLE;
          end else if (cfg.mbe && (in_sat > {3'd0, cfg.chunk})) begin
            state_d = sdio_ts_pkg::ST_BCHK;
          end else begin
            state_d = sdio_ts_pkg::ST_BYTE;
          end
        end
      end
      sdio_ts_pkg::ST_BCHK: begin
        state_d = div_req.start ? sdio_ts_pkg::ST_DIV : sdio_ts_pkg::ST_BYTE;
      end
      sdio_ts_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          blocks_d = (div_rsp.quotient > {4'd0, maxb_q}) ?
                     maxb_q : div_rsp.quotient[sdio_ts_pkg::MAXB_W-1:0];
          state_d  = sdio_ts_pkg::ST_MUL;
        end
      end
      sdio_ts_pkg::ST_MUL: begin
        sz_d    = prod[sdio_ts_pkg::BYTES_W-1:0];
        state_d = sdio_ts_pkg::ST_BEMIT;
      end
      sdio_ts_pkg::ST_BEMIT, sdio_ts_pkg::ST_BYTE: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          if (addr_q[sdio_ts_pkg::ADDR_W]) begin
            oarg_d   = '0;
            obytes_d = '0;
            ostat_d  = 1'b1;
            olast_d  = 1'b1;
            state_d  = sdio_ts_pkg::ST_IDLE;
          end else begin
            if (state_q == sdio_ts_pkg::ST_BEMIT) begin
              oarg_d = {wr_q, fn_q, 1'b1, inc_q, addr_q[sdio_ts_pkg::ADDR_W-1:0], blocks_q};
            end else begin
              oarg_d = {wr_q, fn_q, 1'b0, inc_q, addr_q[sdio_ts_pkg::ADDR_W-1:0], bsz[8:0]};
            end
            obytes_d = esz;
            ostat_d  = 1'b0;
            olast_d  = run_end;
            rem_d    = rem_new;
            n_d      = n_new;
            if (inc_q) begin
              addr_d = addr_q + {5'd0, esz};
            end
            if (run_end) begin
              state_d = sdio_ts_pkg::ST_IDLE;
            end else if (state_q == sdio_ts_pkg::ST_BEMIT) begin
              state_d = sdio_ts_pkg::ST_BCHK;
            end
          end
        end
      end
      default: state_d = sdio_ts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdio_ts_pkg::ST_IDLE;
      n_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    fn_q     <= fn_d;
    inc_q    <= inc_d;
    addr_q   <= addr_d;
    rem_q    <= rem_d;
    bs_q     <= bs_d;
    maxb_q   <= maxb_d;
    chunk_q  <= chunk_d;
    blocks_q <= blocks_d;
    sz_q     <= sz_d;
    oarg_q   <= oarg_d;
    obytes_q <= obytes_d;
    ostat_q  <= ostat_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'd0, obytes_q, oarg_q};
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;

  `SDIO_TS_ASSERT(a_cap, n_q <= sdio_ts_pkg::RESULT_CAP)
  `SDIO_TS_ASSERT_IMP(a_err_payload, ovalid_q && ostat_q,
                      oarg_q == '0 && obytes_q == '0 && olast_q)
  `SDIO_TS_ASSERT_IMP(a_blk_size, state_q == sdio_ts_pkg::ST_BEMIT,
                      sz_q != '0 && sz_q <= rem_q)
  `SDIO_TS_ASSERT_IMP(a_div_quot, div_rsp.done, div_rsp.quotient != '0)

endmodule
